FILE: hdl/fec_pkg.sv
package fec_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 24;
  localparam int unsigned COEFF_BITS_DEF  = 24;

  // internal fixed point: 25 fractional bits for samples/state, 24 for gains
  localparam int unsigned SW     = 28;
  localparam int unsigned IFRAC  = 25;
  localparam int unsigned GFRAC  = 24;
  localparam int unsigned AMT_W  = 17;

  // shared multiplier operands and product
  localparam int unsigned AW   = 34;
  localparam int unsigned BW   = 29;
  localparam int unsigned PW   = AW + BW;
  localparam int unsigned ACCW = 64;

  // divider / square root
  localparam int unsigned DIV_STEPS  = 27;
  localparam int unsigned QW         = DIV_STEPS + 1;
  localparam int unsigned DVW        = 29;
  localparam int unsigned SQRT_STEPS = 26;
  localparam int unsigned SNW        = 2 * SQRT_STEPS;
  localparam int unsigned SRW        = 30;
  localparam int unsigned GW         = 25;
  localparam int unsigned RATIO_W    = 27;
  localparam int unsigned MIX_STEPS  = 8;
  localparam int unsigned NUM_FOLLOW = 6;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SEL_W      = 3;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEFF = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_COEFF = 4'd3;

  localparam logic [DVW-1:0]   EPS_Q       = 29'd3355;
  localparam logic [QW-1:0]    BODY_LO     = 28'd10066330;
  localparam logic [QW-1:0]    BODY_HI     = 28'd27682406;
  localparam logic [SQRT_STEPS-1:0] AIR_LO = 26'd14260634;
  localparam logic [SQRT_STEPS-1:0] AIR_HI = 26'd23488102;
  localparam logic [QW-1:0]    RATIO_MAX   = 28'd67108864;
  localparam logic [AMT_W-1:0] AMOUNT_ONE  = 17'd65536;
  localparam logic signed [BW-1:0] AIR_SCALE = 29'sd36045;
  localparam logic signed [BW-1:0] GAIN_ONE  = 29'sd16777216;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_FMUL, OP_FUPD, OP_DINIT, OP_DSTEP, OP_DEND,
    OP_SINIT, OP_SSTEP, OP_SEND, OP_MBODY, OP_MBODYW, OP_MT, OP_MAIR,
    OP_MAIRW, OP_S1, OP_S2, OP_S3, OP_OUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SEL_W-1:0] sel;
  } fec_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_busy;
  } fec_status_t;

  function automatic op_e mix_op(input logic [SEL_W-1:0] i);
    op_e o;
    unique case (i)
      3'd0: o = OP_MBODY;
      3'd1: o = OP_MBODYW;
      3'd2: o = OP_MT;
      3'd3: o = OP_MAIR;
      3'd4: o = OP_MAIRW;
      3'd5: o = OP_S1;
      3'd6: o = OP_S2;
      default: o = OP_S3;
    endcase
    return o;
  endfunction

  // arithmetic shift right, rounding half up; s >= 1
  function automatic logic signed [ACCW-1:0] rsh(input logic signed [ACCW-1:0] v,
                                                  input int unsigned s);
    logic signed [ACCW-1:0] r;
    r = (v + (64'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

endpackage

FILE: hdl/fec_in_if.sv
interface fec_in_if #(
  parameter int unsigned SAMPLE_BITS = fec_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] orig_sample;
  logic signed [SAMPLE_BITS-1:0] shifted_sample;

  modport source (output valid, orig_sample, shifted_sample, input ready);
  modport sink (input valid, orig_sample, shifted_sample, output ready);
endinterface

FILE: hdl/fec_out_if.sv
interface fec_out_if #(
  parameter int unsigned SAMPLE_BITS = fec_pkg::SAMPLE_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] out_sample;

  modport source (output valid, out_sample, input ready);
  modport sink (input valid, out_sample, output ready);
endinterface

FILE: hdl/formant_envelope_compensator.sv
// channel  dir  handshake          payload
// in_if    in   valid/ready        orig_sample, shifted_sample (signed SAMPLE_BITS)
// out_if   out  valid/ready        out_sample (signed SAMPLE_BITS+1)
// cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// Compensated item: follower filter updates, then two 27-step divides on one
// shared divider, a 26-step square root and the mix steps.
// Bypassed item: passed from the decide state straight to the output.
// A new item is taken only once the last one is in the output register.
// Reset clears filter state, configuration and the output valid.
// A result waits in the output register; the next item is taken meanwhile.
module formant_envelope_compensator #(
  parameter int unsigned SAMPLE_BITS = fec_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEFF_BITS  = fec_pkg::COEFF_BITS_DEF,
  parameter int unsigned CFG_W       = (COEFF_BITS > 17) ? COEFF_BITS : 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fec_in_if.sink                        in_if,
  fec_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [fec_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);
  import fec_pkg::*;

  fec_cmd_t    cmd;
  fec_status_t status;

  fec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fec_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS),
    .CFG_W       (CFG_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .orig_sample_i    (in_if.orig_sample),
    .shifted_sample_i (in_if.shifted_sample),
    .out_sample_o     (out_if.out_sample),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .cmd_i            (cmd),
    .status_o         (status)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("item accepted while busy");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(!in_if.ready))
    else $error("result without item in flight");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.out_sample <= $signed((SAMPLE_BITS+1)'(1) << (SAMPLE_BITS-1)))
                  && (out_if.out_sample >= -$signed((SAMPLE_BITS+1)'(1) << (SAMPLE_BITS-1))))
    else $error("output beyond saturation");

endmodule

FILE: hdl/fec_ctrl.sv
module fec_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fec_pkg::fec_status_t status_i,
  output fec_pkg::fec_cmd_t    cmd_o
);
  import fec_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECIDE = 12'b000000000010,
    S_FMUL   = 12'b000000000100,
    S_FUPD   = 12'b000000001000,
    S_DINIT  = 12'b000000010000,
    S_DSTEP  = 12'b000000100000,
    S_DEND   = 12'b000001000000,
    S_SINIT  = 12'b000010000000,
    S_SSTEP  = 12'b000100000000,
    S_SEND   = 12'b001000000000,
    S_MIX    = 12'b010000000000,
    S_FINAL  = 12'b100000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SEL_W-1:0] sel_q, sel_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = sel_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        sel_d   = '0;
        state_d = status_i.bypass ? S_FINAL : S_FMUL;
      end
      S_FMUL: begin
        cmd_o.op = OP_FMUL;
        state_d  = S_FUPD;
      end
      S_FUPD: begin
        cmd_o.op = OP_FUPD;
        if (sel_q == SEL_W'(NUM_FOLLOW - 1)) begin
          sel_d   = '0;
          state_d = S_DINIT;
        end else begin
          sel_d   = sel_q + 1'b1;
          state_d = S_FMUL;
        end
      end
      S_DINIT: begin
        cmd_o.op = OP_DINIT;
        cnt_d    = '0;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = OP_DSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_DEND;
      end
      S_DEND: begin
        cmd_o.op = OP_DEND;
        if (sel_q == '0) begin
          sel_d   = SEL_W'(1);
          state_d = S_DINIT;
        end else begin
          state_d = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd_o.op = OP_SINIT;
        cnt_d    = '0;
        state_d  = S_SSTEP;
      end
      S_SSTEP: begin
        cmd_o.op = OP_SSTEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_SEND;
      end
      S_SEND: begin
        cmd_o.op = OP_SEND;
        cnt_d    = '0;
        state_d  = S_MIX;
      end
      S_MIX: begin
        cmd_o.op = mix_op(cnt_q[SEL_W-1:0]);
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MIX_STEPS - 1)) state_d = S_FINAL;
      end
      S_FINAL: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

endmodule

FILE: hdl/fec_dp.sv
module fec_dp #(
  parameter int unsigned SAMPLE_BITS = fec_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEFF_BITS  = fec_pkg::COEFF_BITS_DEF,
  parameter int unsigned CFG_W       = (COEFF_BITS > 17) ? COEFF_BITS : 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fec_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]                  cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]     orig_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]     shifted_sample_i,
  output logic signed [SAMPLE_BITS:0]       out_sample_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  fec_pkg::fec_cmd_t                 cmd_i,
  output fec_pkg::fec_status_t              status_o
);
  import fec_pkg::*;

  localparam int KIN = IFRAC + 1 - SAMPLE_BITS;
  localparam int unsigned KL  = (KIN >= 0) ? KIN : 0;
  localparam int unsigned KR  = (KIN < 0) ? -KIN : 0;
  localparam int unsigned KRM = (KR > 0) ? KR - 1 : 0;
  localparam logic signed [ACCW-1:0] RND_IN = (KR > 0) ? (64'sd1 <<< KRM) : 64'sd0;
  localparam int unsigned OSH = IFRAC + GFRAC + 2 - SAMPLE_BITS;
  localparam logic signed [ACCW-1:0] OMAX = 64'sd1 <<< (SAMPLE_BITS - 1);

  // configuration
  logic                  en_q;
  logic [AMT_W-1:0]      mix_q;
  logic [COEFF_BITS-1:0] lc_q, ec_q;

  // item
  logic signed [SW-1:0]          xo_q, xs_q;
  logic signed [SAMPLE_BITS-1:0] xs_raw_q;
  logic [AMT_W-1:0]              amt_q;
  logic                          byp_q;

  // filter state
  logic signed [SW-1:0] ol_q, sl_q, oe_q, se_q, ohe_q, she_q;

  logic signed [PW-1:0]   p_q;
  logic signed [ACCW-1:0] acc_q;

  logic [DVW-1:0]         rem_q, dv_q;
  logic [DIV_STEPS-1:0]   dd_q, q_q;
  logic                   sat_q;
  logic [GW-1:0]          body_q;
  logic [RATIO_W-1:0]     ratio_q;
  logic [SNW-1:0]         sn_q;
  logic [SRW-1:0]         srem_q;
  logic [SQRT_STEPS-1:0]  sr_q;
  logic [GW-1:0]          air_q;
  logic signed [GW+1:0]   bodyf_q, airf_q;

  logic signed [SAMPLE_BITS:0] out_q;
  logic                        out_v_q;

  // combinational
  logic signed [ACCW-1:0] xo_w, xs_w;
  logic signed [SW:0]     ho_w, hs_w;
  logic signed [SW-1:0]   y_sel, x_sel, fol_new;
  logic [COEFF_BITS-1:0]  c_sel;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   prod;
  logic [SW-1:0]          num_sel, den_sel;
  logic [DVW-1:0]         dv_new;
  logic [DVW:0]           dt;
  logic                   dge;
  logic [QW-1:0]          qfull;
  logic [SRW-1:0]         st, strial;
  logic                   sge;
  logic signed [ACCW-1:0] yc;
  logic signed [SAMPLE_BITS:0] ybyp, yout;

  function automatic logic signed [SW-1:0] absw(input logic signed [SW:0] v);
    logic signed [SW:0] a;
    a = (v < 0) ? -v : v;
    return a[SW-1:0];
  endfunction

  assign xo_w = ((ACCW'(orig_sample_i) <<< KL) + RND_IN) >>> KR;
  assign xs_w = ((ACCW'(shifted_sample_i) <<< KL) + RND_IN) >>> KR;
  assign ho_w = (SW+1)'(xo_q) - (SW+1)'(ol_q);
  assign hs_w = (SW+1)'(xs_q) - (SW+1)'(sl_q);

  always_comb begin
    unique case (cmd_i.sel)
      3'd0: begin y_sel = ol_q;  x_sel = xo_q;       end
      3'd1: begin y_sel = sl_q;  x_sel = xs_q;       end
      3'd2: begin y_sel = oe_q;  x_sel = absw((SW+1)'(ol_q)); end
      3'd3: begin y_sel = se_q;  x_sel = absw((SW+1)'(sl_q)); end
      3'd4: begin y_sel = ohe_q; x_sel = absw(ho_w); end
      default: begin y_sel = she_q; x_sel = absw(hs_w); end
    endcase
  end

  assign c_sel   = (cmd_i.sel < SEL_W'(2)) ? lc_q : ec_q;
  assign fol_new = y_sel + SW'(rsh(ACCW'(p_q), COEFF_BITS));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_FMUL: begin
        mul_a = AW'(c_sel);
        mul_b = BW'(x_sel) - BW'(y_sel);
      end
      OP_MBODY: begin
        mul_a = AW'(amt_q);
        mul_b = BW'(body_q) - GAIN_ONE;
      end
      OP_MT: begin
        mul_a = AW'(amt_q);
        mul_b = AIR_SCALE;
      end
      OP_MAIR: begin
        mul_a = p_q[AW-1:0];
        mul_b = BW'(air_q) - GAIN_ONE;
      end
      OP_S1: begin
        mul_a = AW'(bodyf_q);
        mul_b = BW'(sl_q);
      end
      OP_S2: begin
        mul_a = AW'(airf_q);
        mul_b = BW'(hs_w);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // divider
  assign num_sel = (cmd_i.sel == '0) ? oe_q : ohe_q;
  assign den_sel = (cmd_i.sel == '0) ? se_q : she_q;
  assign dv_new  = DVW'(den_sel) + EPS_Q;
  assign dt      = {rem_q, dd_q[DIV_STEPS-1]};
  assign dge     = dt >= {1'b0, dv_q};
  assign qfull   = sat_q ? (QW'(1) << DIV_STEPS) : QW'(q_q);

  // square root
  assign st     = {srem_q[SRW-3:0], sn_q[SNW-1:SNW-2]};
  assign strial = SRW'({sr_q, 2'b01});
  assign sge    = st >= strial;

  assign yc   = rsh(acc_q, OSH);
  assign ybyp = ((SAMPLE_BITS+1)'(xs_raw_q) + (SAMPLE_BITS+1)'(1)) >>> 1;
  assign yout = byp_q ? ybyp
              : (yc > OMAX) ? (SAMPLE_BITS+1)'(OMAX)
              : (yc < -OMAX) ? (SAMPLE_BITS+1)'(-OMAX)
              : (SAMPLE_BITS+1)'(yc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      mix_q   <= '0;
      lc_q    <= '0;
      ec_q    <= '0;
      ol_q    <= '0;
      sl_q    <= '0;
      oe_q    <= '0;
      se_q    <= '0;
      ohe_q   <= '0;
      she_q   <= '0;
      byp_q   <= 1'b1;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ENABLE:    en_q  <= cfg_data_i[0];
          REG_MIX:       mix_q <= cfg_data_i[AMT_W-1:0];
          REG_LOW_COEFF: lc_q  <= cfg_data_i[COEFF_BITS-1:0];
          REG_ENV_COEFF: ec_q  <= cfg_data_i[COEFF_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_OUT) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      unique case (cmd_i.op)
        OP_LOAD: byp_q <= !en_q || (mix_q == '0);
        OP_FUPD: begin
          unique case (cmd_i.sel)
            3'd0: ol_q  <= fol_new;
            3'd1: sl_q  <= fol_new;
            3'd2: oe_q  <= fol_new;
            3'd3: se_q  <= fol_new;
            3'd4: ohe_q <= fol_new;
            default: she_q <= fol_new;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        xo_q     <= SW'(xo_w);
        xs_q     <= SW'(xs_w);
        xs_raw_q <= shifted_sample_i;
        amt_q    <= (mix_q > AMOUNT_ONE) ? AMOUNT_ONE : mix_q;
      end
      OP_FMUL, OP_MBODY, OP_MT, OP_MAIR, OP_S1: p_q <= prod;
      OP_S2: begin
        acc_q <= ACCW'(p_q);
        p_q   <= prod;
      end
      OP_S3: acc_q <= acc_q + ACCW'(p_q);
      OP_DINIT: begin
        dv_q  <= dv_new;
        sat_q <= {4'b0, num_sel} >= {dv_new, 3'b000};
        rem_q <= DVW'(num_sel[SW-1:3]);
        dd_q  <= {num_sel[2:0], {GFRAC{1'b0}}};
        q_q   <= '0;
      end
      OP_DSTEP: begin
        rem_q <= dge ? DVW'(dt - {1'b0, dv_q}) : DVW'(dt);
        q_q   <= {q_q[DIV_STEPS-2:0], dge};
        dd_q  <= {dd_q[DIV_STEPS-2:0], 1'b0};
      end
      OP_DEND: begin
        if (cmd_i.sel == '0) begin
          body_q <= (qfull < BODY_LO) ? GW'(BODY_LO)
                  : (qfull > BODY_HI) ? GW'(BODY_HI) : GW'(qfull);
        end else begin
          ratio_q <= (qfull > RATIO_MAX) ? RATIO_W'(RATIO_MAX) : RATIO_W'(qfull);
        end
      end
      OP_SINIT: begin
        sn_q   <= {1'b0, ratio_q, {GFRAC{1'b0}}};
        srem_q <= '0;
        sr_q   <= '0;
      end
      OP_SSTEP: begin
        srem_q <= sge ? (st - strial) : st;
        sr_q   <= {sr_q[SQRT_STEPS-2:0], sge};
        sn_q   <= {sn_q[SNW-3:0], 2'b00};
      end
      OP_SEND: begin
        air_q <= (sr_q < AIR_LO) ? GW'(AIR_LO)
               : (sr_q > AIR_HI) ? GW'(AIR_HI) : GW'(sr_q);
      end
      OP_MBODYW: bodyf_q <= (GW+2)'(GAIN_ONE) + (GW+2)'(rsh(ACCW'(p_q), 16));
      OP_MAIRW:  airf_q  <= (GW+2)'(GAIN_ONE) + (GW+2)'(rsh(ACCW'(p_q), 32));
      OP_OUT:    out_q   <= yout;
      default: ;
    endcase
  end

  assign out_sample_o      = out_q;
  assign out_valid_o       = out_v_q;
  assign status_o.bypass   = byp_q;
  assign status_o.out_busy = out_v_q && !out_ready_i;

endmodule
